// File: rtl/uwt_pkg.sv
`timescale 1ns / 1ps
package uwt_pkg;

  localparam int unsigned MaxResults   = 3;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned CodeW        = 21;

  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [7:0] Mask3Hi   = 8'hE0;
  localparam logic [7:0] Lead2     = 8'hC0;
  localparam logic [7:0] Mask4Hi   = 8'hF0;
  localparam logic [7:0] Lead3     = 8'hE0;
  localparam logic [7:0] Mask5Hi   = 8'hF8;
  localparam logic [7:0] Lead4     = 8'hF0;
  localparam logic [7:0] ContMask  = 8'h3F;
  localparam logic [7:0] ContMark  = 8'h80;

  localparam logic [CodeW-1:0] CyrCapLo  = 21'h000410;
  localparam logic [CodeW-1:0] CyrCapHi  = 21'h00042F;
  localparam logic [CodeW-1:0] CyrSmLo   = 21'h000430;
  localparam logic [CodeW-1:0] CyrSmHi   = 21'h00044F;
  localparam logic [CodeW-1:0] CapYo     = 21'h000401;
  localparam logic [CodeW-1:0] SmallYo   = 21'h000451;
  localparam logic [CodeW-1:0] SmallYe   = 21'h000435;
  localparam logic [CodeW-1:0] CapUkrYe  = 21'h000404;
  localparam logic [CodeW-1:0] SmUkrYe   = 21'h000454;
  localparam logic [CodeW-1:0] CapUkrI   = 21'h000406;
  localparam logic [CodeW-1:0] SmUkrI    = 21'h000456;
  localparam logic [CodeW-1:0] CapUkrYi  = 21'h000407;
  localparam logic [CodeW-1:0] SmUkrYi   = 21'h000457;
  localparam logic [CodeW-1:0] CapGhe    = 21'h000490;
  localparam logic [CodeW-1:0] SmGhe     = 21'h000491;
  localparam logic [CodeW-1:0] CaseShift = 21'h000020;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } uwt_in_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_byte;
    logic       last_of_run;
  } uwt_out_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    uwt_out_t [MaxResults-1:0]    res;
  } uwt_grp_t;

  function automatic logic [CodeW-1:0] fold_case(input logic [CodeW-1:0] cp);
    logic [CodeW-1:0] r;
    r = cp;
    if (cp >= 21'h41 && cp <= 21'h5A) r = cp + CaseShift;
    else if (cp >= CyrCapLo && cp <= CyrCapHi) r = cp + CaseShift;
    else if (cp == CapYo || cp == SmallYo) r = SmallYe;
    else if (cp == CapUkrYe) r = SmUkrYe;
    else if (cp == CapUkrI) r = SmUkrI;
    else if (cp == CapUkrYi) r = SmUkrYi;
    else if (cp == CapGhe) r = SmGhe;
    return r;
  endfunction

  function automatic logic is_word(input logic [CodeW-1:0] cp);
    return (cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'h30 && cp <= 21'h39) ||
           (cp >= CyrSmLo && cp <= CyrSmHi) || cp == SmUkrYe ||
           cp == SmUkrI || cp == SmUkrYi || cp == SmGhe;
  endfunction

endpackage

// File: rtl/uwt_front.sv
`timescale 1ns / 1ps
module uwt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  uwt_pkg::uwt_in_t in_data_i,
  input  logic             full_i,
  output logic             push_o,
  output uwt_pkg::uwt_grp_t grp_o
);
  import uwt_pkg::*;

  logic             tok_q, tok_d;
  logic [1:0]       pend_q, pend_d;
  logic [CodeW-1:0] acc_q, acc_d;

  logic             accept;
  logic [7:0]       b;
  logic             cont;
  logic             cp_take;
  logic [CodeW-1:0] cp, cp_f, acc_n;
  logic             tok;
  logic [1:0]       n;
  uwt_out_t [MaxResults-1:0] res;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign b          = in_data_i.in_byte;
  assign cont       = (b & ~ContMask) == ContMark;
  assign acc_n      = {acc_q[CodeW-7:0], b[5:0]};

  always_comb begin
    res     = '0;
    n       = 2'd0;
    tok     = tok_q;
    pend_d  = pend_q;
    acc_d   = acc_q;
    cp_take = 1'b0;
    cp      = '0;
    // broken sequence: close token, byte is retried as a lead
    if (pend_q != 2'd0 && !cont) begin
      if (tok) begin
        res[n].out_kind = KindEnd;
        n = n + 2'd1;
      end
      tok    = 1'b0;
      pend_d = 2'd0;
      acc_d  = '0;
    end
    if (pend_q == 2'd0 || !cont) begin
      if (!b[7]) begin
        cp_take = 1'b1;
        cp      = {13'd0, b};
      end else if ((b & Mask3Hi) == Lead2) begin
        pend_d = 2'd1;
        acc_d  = {16'd0, b[4:0]};
      end else if ((b & Mask4Hi) == Lead3) begin
        pend_d = 2'd2;
        acc_d  = {17'd0, b[3:0]};
      end else if ((b & Mask5Hi) == Lead4) begin
        pend_d = 2'd3;
        acc_d  = {18'd0, b[2:0]};
      end else begin
        if (tok) begin
          res[n].out_kind = KindEnd;
          n = n + 2'd1;
        end
        tok = 1'b0;
      end
    end else begin
      pend_d = pend_q - 2'd1;
      if (pend_q == 2'd1) begin
        cp_take = 1'b1;
        cp      = acc_n;
        acc_d   = '0;
      end else begin
        acc_d = acc_n;
      end
    end
    cp_f = fold_case(cp);
    if (cp_take) begin
      if (is_word(cp_f)) begin
        if (cp_f[CodeW-1:7] == '0) begin
          res[n].out_kind = KindByte;
          res[n].out_byte = cp_f[7:0];
          n = n + 2'd1;
        end else begin
          res[n].out_kind = KindByte;
          res[n].out_byte = Lead2 | {3'd0, cp_f[10:6]};
          n = n + 2'd1;
          res[n].out_kind = KindByte;
          res[n].out_byte = ContMark | {2'd0, cp_f[5:0]};
          n = n + 2'd1;
        end
        tok = 1'b1;
      end else begin
        if (tok) begin
          res[n].out_kind = KindEnd;
          n = n + 2'd1;
        end
        tok = 1'b0;
      end
    end
    if (in_data_i.end_of_text) begin
      if (tok) begin
        res[n].out_kind = KindEnd;
        n = n + 2'd1;
      end
      tok    = 1'b0;
      pend_d = 2'd0;
      acc_d  = '0;
    end
    if (n != 2'd0) begin
      res[n - 2'd1].last_of_run = 1'b1;
    end
    tok_d = tok;
  end

  assign grp_o.cnt = n;
  assign grp_o.res = res;
  assign push_o    = accept && (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= 1'b0;
      pend_q <= 2'd0;
      acc_q  <= '0;
    end else if (accept) begin
      tok_q  <= tok_d;
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

`ifndef SYNTHESIS
  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.end_of_text |=> pend_q == 2'd0 && !tok_q && acc_q == '0)
    else $error("state not cleared after end of text");
  a_tok_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tok_q) |-> $past(push_o && grp_o.res[0].out_kind == KindByte ||
                           push_o && grp_o.res[1].out_kind == KindByte))
    else $error("token opened without a token byte");
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd0 |-> acc_q == '0)
    else $error("stale accumulator with no sequence pending");
`endif
endmodule

// File: rtl/uwt_queue.sv
`timescale 1ns / 1ps
module uwt_queue #(
  parameter int unsigned DEPTH = uwt_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  uwt_pkg::uwt_grp_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output uwt_pkg::uwt_grp_t head_o
);
  import uwt_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  uwt_grp_t        mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("transfer into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from an empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count out of range");
`endif
endmodule

// File: rtl/uwt_back.sv
`timescale 1ns / 1ps
module uwt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  uwt_pkg::uwt_grp_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output uwt_pkg::uwt_out_t out_data_o
);
  import uwt_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       xfer;
  logic       at_last;

  assign out_valid_o = !empty_i;
  assign out_data_o  = head_i.res[idx_q];
  assign xfer        = out_valid_o && !out_stall_i;
  assign at_last     = idx_q == head_i.cnt - 2'd1;
  assign pop_o       = xfer && at_last;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = at_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q < head_i.cnt)
    else $error("result index beyond group");
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.last_of_run == at_last)
    else $error("last_of_run does not match end of group");
  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == 2'd0)
    else $error("index left mid-group with queue empty");
`endif
endmodule

// File: rtl/utf8_word_tokenizer_core.sv
`timescale 1ns / 1ps
// utf8 word tokeniser
// input channel: one text byte per transfer (in_byte, end_of_text), valid/stall
// output channel: one result per transfer (out_kind, out_byte, last_of_run)
// a byte gives zero to three results: token bytes and end of token marks
// last_of_run flags the final result of each input byte; bytes with no result
// produce nothing on the output
// results are registered: a byte's result group is written to the queue before it is offered
// throughput: one byte per cycle while the queue has room; the output side
// moves one result per cycle while out_stall_i is low, so bytes with two or
// three results drain at that rate, set by the single output port behind the
// group queue; the decoder holds a queue of DEPTH result groups; in_stall_o
// rises only when that queue is full, so input keeps flowing while the
// receiver stalls for up to DEPTH groups
// reset: no token open, no sequence pending, queue empty
module utf8_word_tokenizer_core #(
  parameter int unsigned DEPTH = uwt_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  uwt_pkg::uwt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output uwt_pkg::uwt_out_t out_data_o
);
  import uwt_pkg::*;

  logic     full, empty, push, pop;
  uwt_grp_t grp, head;

  uwt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .grp_o      (grp)
  );

  uwt_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (grp),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  uwt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );
endmodule
